>>> rtl/core/bfac_pkg.sv
// Shared constants and types for the Bloom filter add/check unit.
// Depends on nothing; every other file of the block but bfac_ram uses it by scoped names.

package bfac_pkg;

  // Store geometry and probe limits.
  localparam int unsigned FILTER_BITS_DEF = 65536;
  localparam int unsigned MAX_HASHES      = 16;

  // Field widths.
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned COUNT_W = 5;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT  = 2'd1;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 17'd65536;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd4;

  // Operation codes.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Modulo reducer: two key bits per cycle.
  localparam int unsigned DIGIT_W   = 2;
  localparam int unsigned RED_STEPS = KEY_W / DIGIT_W;
  localparam int unsigned STEP_W    = $clog2(RED_STEPS);

  // Response of the modulo reducer to the sequencer.
  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } red_rsp_t;

endpackage

>>> rtl/core/bfac_if.sv
// Valid/ready channel interfaces for the Bloom filter add/check unit.
// Depends on bfac_pkg for field widths.

interface bfac_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [bfac_pkg::KEY_W-1:0]    key_low;
  logic [bfac_pkg::KEY_W-1:0]    key_high;

  modport source (output valid, output op, output key_low, output key_high, input ready);
  modport sink   (input valid, input op, input key_low, input key_high, output ready);
endinterface

interface bfac_out_if;
  logic valid;
  logic ready;
  logic maybe_present;

  modport source (output valid, output maybe_present, input ready);
  modport sink   (input valid, input maybe_present, output ready);
endinterface

>>> rtl/core/bfac_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.

module bfac_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bfac_mod_reducer.sv
// Radix-4 serial modulo unit: reduces a 64-bit probe value by the filter size,
// two bits per cycle, MSB first. Depends on bfac_pkg.

module bfac_mod_reducer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bfac_pkg::KEY_W-1:0]    value,
  input  logic [bfac_pkg::SIZE_W-1:0]   size,
  output bfac_pkg::red_rsp_t            rsp
);

  localparam int unsigned TW = bfac_pkg::SIZE_W + bfac_pkg::DIGIT_W;

  logic [bfac_pkg::KEY_W-1:0]  val_r, val_nxt;
  logic [bfac_pkg::SIZE_W-1:0] rem_r, rem_nxt;
  logic [TW-1:0]               m1_r, m2_r, m3_r;
  logic [bfac_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [TW-1:0]               trial;
  logic [TW-1:0]               reduced;

  // The partial remainder stays below the size, so after shifting in one
  // digit at most three subtractions of the size are needed.
  assign trial = {rem_r, val_r[bfac_pkg::KEY_W-1 -: bfac_pkg::DIGIT_W]};

  always_comb begin
    if (trial >= m3_r) begin
      reduced = trial - m3_r;
    end else if (trial >= m2_r) begin
      reduced = trial - m2_r;
    end else if (trial >= m1_r) begin
      reduced = trial - m1_r;
    end else begin
      reduced = trial;
    end
  end

  always_comb begin
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      val_nxt  = value;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt  = val_r << bfac_pkg::DIGIT_W;
      rem_nxt  = reduced[bfac_pkg::SIZE_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == bfac_pkg::STEP_W'(bfac_pkg::RED_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      m1_r <= TW'(size);
      m2_r <= TW'(size) << 1;
      m3_r <= TW'(size) + (TW'(size) << 1);
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

>>> rtl/core/bloom_filter_add_check_unit.sv
// Top level of the Bloom filter add/check unit: sequencer, configuration,
// output register. Depends on bfac_pkg, bfac_if, bfac_ram, bfac_mod_reducer.
//
//   channel   | direction | handshake    | word contents
//   ----------+-----------+--------------+-------------------------------
//   in_ch     | sink      | valid/ready  | op, key_low, key_high
//   out_ch    | source    | valid/ready  | maybe_present
//   cfg_*     | sink      | cfg_we only  | cfg_index, cfg_wdata
//
// Each probe passes through the launch state and the radix-4 modulo reducer
// (two key bits a cycle) with its done strobe; a check adds a state for the
// store read.
// After reset the store is cleared one bit a cycle over all FILTER_BITS cells, while
// in_ch.ready stays low; configuration writes are taken throughout.
// One result word waits in the output register, so the next input word is
// taken while a finished result is still stalled on out_ch.

module bloom_filter_add_check_unit #(
  parameter int unsigned FILTER_BITS = bfac_pkg::FILTER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bfac_in_if.sink                           in_ch,
  bfac_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [bfac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfac_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned AW = $clog2(FILTER_BITS);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_REDUCE = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_r, state_nxt;

  // Configuration registers.
  logic [bfac_pkg::SIZE_W-1:0]  size_cfg_r;
  logic [bfac_pkg::COUNT_W-1:0] count_cfg_r;

  // Per-word working registers.
  logic                         op_r, op_nxt;
  logic [bfac_pkg::KEY_W-1:0]   acc_r, acc_nxt;
  logic [bfac_pkg::KEY_W-1:0]   h2_r, h2_nxt;
  logic [bfac_pkg::SIZE_W-1:0]  size_r, size_nxt;
  logic [bfac_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [bfac_pkg::COUNT_W-1:0] probe_r, probe_nxt;
  logic                         all_set_r, all_set_nxt;
  logic [AW-1:0]                clr_addr_r, clr_addr_nxt;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  logic out_maybe_r, out_maybe_nxt;

  // Effective configuration, saturated to the store and the probe limit.
  logic [bfac_pkg::SIZE_W-1:0]  size_eff;
  logic [bfac_pkg::COUNT_W-1:0] count_eff;

  // Store and reducer hookup.
  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  logic                        ram_wdata;
  logic                        ram_rdata;
  logic                        red_start;
  bfac_pkg::red_rsp_t          red_rsp;
  logic [AW+bfac_pkg::SIZE_W-1:0] rem_wide;
  logic                        in_fire;
  logic                        out_free;

  assign size_eff  = (32'(size_cfg_r) > 32'(FILTER_BITS)) ? bfac_pkg::SIZE_W'(FILTER_BITS)
                                                          : size_cfg_r;
  assign count_eff = (32'(count_cfg_r) > 32'(bfac_pkg::MAX_HASHES))
                     ? bfac_pkg::COUNT_W'(bfac_pkg::MAX_HASHES) : count_cfg_r;

  // The remainder is below the effective size, which never exceeds the store,
  // so it always fits the address width.
  assign rem_wide = {{AW{1'b0}}, red_rsp.rem};

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r  <= bfac_pkg::SIZE_RESET;
      count_cfg_r <= bfac_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bfac_pkg::REG_FILTER_SIZE: size_cfg_r  <= cfg_wdata;
        bfac_pkg::REG_HASH_COUNT:  count_cfg_r <= cfg_wdata[bfac_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    acc_nxt       = acc_r;
    h2_nxt        = h2_r;
    size_nxt      = size_r;
    count_nxt     = count_r;
    probe_nxt     = probe_r;
    all_set_nxt   = all_set_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r;
    out_maybe_nxt = out_maybe_r;
    ram_we        = 1'b0;
    ram_addr      = rem_wide[AW-1:0];
    ram_wdata     = 1'b1;
    red_start     = 1'b0;

    // The consumer takes the waiting result.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        ram_wdata    = 1'b0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(FILTER_BITS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_ch.op;
          acc_nxt     = in_ch.key_low;
          h2_nxt      = in_ch.key_high | bfac_pkg::KEY_W'(1);
          size_nxt    = size_eff;
          count_nxt   = count_eff;
          probe_nxt   = '0;
          // A zero size answers no; zero probes leave the check answering yes.
          all_set_nxt = (size_eff != '0);
          if (size_eff == '0 || count_eff == '0) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_LAUNCH;
          end
        end
      end
      S_LAUNCH: begin
        // The reducer takes the current probe value; the next one is formed
        // by one add of h2 with 64-bit wraparound.
        red_start = 1'b1;
        acc_nxt   = acc_r + h2_r;
        state_nxt = S_REDUCE;
      end
      S_REDUCE: begin
        if (red_rsp.done) begin
          probe_nxt = probe_r + 1'b1;
          if (op_r == bfac_pkg::OP_ADD) begin
            ram_we = 1'b1;
            if (probe_r + 1'b1 == count_r) begin
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_LAUNCH;
            end
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        // Read data for the probe issued last cycle.
        if (!ram_rdata) begin
          all_set_nxt = 1'b0;
        end
        if (probe_r == count_r) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_LAUNCH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_maybe_nxt = (op_r == bfac_pkg::OP_CHECK) && all_set_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      probe_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      probe_r     <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    acc_r       <= acc_nxt;
    h2_r        <= h2_nxt;
    size_r      <= size_nxt;
    count_r     <= count_nxt;
    all_set_r   <= all_set_nxt;
    out_maybe_r <= out_maybe_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.maybe_present = out_maybe_r;

  bfac_ram #(
    .WIDTH (1),
    .DEPTH (FILTER_BITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bfac_mod_reducer u_reducer (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .value (acc_r),
    .size  (size_r),
    .rsp   (red_rsp)
  );

endmodule

>>> tb/tb_bloom_filter_add_check_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for bloom_filter_add_check_unit: directed and random add/check
// words, scored against an in-bench model of the filter store and its two registers.
// Depends on bfac_pkg and the bfac_in_if / bfac_out_if channel interfaces.

module tb_bloom_filter_add_check_unit;

  // Store size of the instance (default parameter) and run guards. The quiet limit
  // covers the store clearing pass after reset (one cell a cycle) several times over,
  // which dwarfs the slowest word plus the longest drawn stall on out_ch.
  localparam int unsigned STORE_CELLS   = bfac_pkg::FILTER_BITS_DEF;
  localparam int unsigned QUIET_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 600;
  localparam int unsigned KEY_HISTORY   = 256;

  // The two register indexes past the end of the map; writes there must be dropped.
  localparam logic [bfac_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [bfac_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

  typedef struct packed {
    logic                       op;
    logic [bfac_pkg::KEY_W-1:0] key_low;
    logic [bfac_pkg::KEY_W-1:0] key_high;
  } bloom_word_t;

  typedef struct packed {
    logic [bfac_pkg::KEY_W-1:0] lo;
    logic [bfac_pkg::KEY_W-1:0] hi;
  } bloom_key_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [bfac_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bfac_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bfac_in_if  in_ch ();
  bfac_out_if out_ch ();

  bloom_filter_add_check_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Model of the block: one flag per store cell plus the raw register contents.
  // Saturation of both registers is applied when a word is scored, as the block does.
  logic                         cell_set [STORE_CELLS];
  logic [bfac_pkg::SIZE_W-1:0]  cur_size;
  logic [bfac_pkg::COUNT_W-1:0] cur_count;

  // Words waiting for the driver, answers waiting for the monitor, and a history of
  // added keys so that checks can hit keys that really are in the filter.
  bloom_word_t words_to_send [$];
  logic        answers_due [$];
  bloom_key_t  added_keys [$];

  int unsigned words_queued = 0;
  int unsigned answers_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned in_gap       = 0;
  int unsigned out_stall    = 0;
  int unsigned quiet_cycles = 0;
  bit          calm_in      = 1'b0;
  bit          calm_out     = 1'b0;

  // Scores one accepted word against the model and updates the store on an add.
  // The probe index h1 + i*h2 (mod 2^64) is built by adding h2 once per probe, which
  // wraps exactly like the multiply form.
  function automatic logic filter_answer(input bloom_word_t w);
    logic [bfac_pkg::KEY_W-1:0] span;
    logic [bfac_pkg::KEY_W-1:0] stride;
    logic [bfac_pkg::KEY_W-1:0] acc;
    logic [bfac_pkg::KEY_W-1:0] pos;
    int unsigned                probes;
    int unsigned                i;
    logic                       all_set;
    span = {{(bfac_pkg::KEY_W-bfac_pkg::SIZE_W){1'b0}}, cur_size};
    if (span > STORE_CELLS) span = bfac_pkg::KEY_W'(STORE_CELLS);
    probes = (cur_count > bfac_pkg::MAX_HASHES) ? bfac_pkg::MAX_HASHES : 32'(cur_count);
    if (span == 0) return 1'b0;
    stride  = w.key_high | 64'd1;
    acc     = w.key_low;
    all_set = 1'b1;
    for (i = 0; i < probes; i++) begin
      pos = acc % span;
      if (w.op == bfac_pkg::OP_ADD) cell_set[pos] = 1'b1;
      else if (!cell_set[pos]) all_set = 1'b0;
      acc = acc + stride;
    end
    return (w.op == bfac_pkg::OP_CHECK) && all_set;
  endfunction

  function automatic int unsigned draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [bfac_pkg::KEY_W-1:0] rand_key_half();
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_word(input logic op, input logic [bfac_pkg::KEY_W-1:0] lo,
                                     input logic [bfac_pkg::KEY_W-1:0] hi);
    bloom_word_t w;
    bloom_key_t  k;
    w.op       = op;
    w.key_low  = lo;
    w.key_high = hi;
    words_to_send.push_back(w);
    words_queued++;
    if (op == bfac_pkg::OP_ADD) begin
      k.lo = lo;
      k.hi = hi;
      added_keys.push_back(k);
      if (added_keys.size() > KEY_HISTORY) void'(added_keys.pop_front());
    end
  endfunction

  // Holds until every queued word has produced its result. Each word yields exactly
  // one result, so the block is idle once the last one has been taken.
  task automatic wait_drained();
    while (answers_seen != words_queued) @(posedge clk);
  endtask

  // One register write: the enable is high for a single edge. The model follows at
  // once, which is safe because registers are only written while the block is idle.
  task automatic write_reg(input logic [bfac_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bfac_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bfac_pkg::REG_FILTER_SIZE) cur_size = val;
    else if (idx == bfac_pkg::REG_HASH_COUNT) cur_count = val[bfac_pkg::COUNT_W-1:0];
  endtask

  // Picks a new filter size and probe count for the next random batch. Sizes lean
  // toward small filters that fill up (so checks answer 1 often) and the full store;
  // probe counts lean low to keep the run short. Upper data bits of the count write
  // carry noise that the block must mask off.
  task automatic pick_setting();
    logic [bfac_pkg::CFG_DATA_W-1:0] sz;
    logic [bfac_pkg::CFG_DATA_W-1:0] raw;
    case ($urandom_range(0, 9))
      0:       sz = '0;
      1, 2, 3: sz = bfac_pkg::CFG_DATA_W'($urandom_range(1, 64));
      4, 5:    sz = bfac_pkg::CFG_DATA_W'($urandom_range(65, 8000));
      6, 7:    sz = bfac_pkg::CFG_DATA_W'(STORE_CELLS);
      8:       sz = bfac_pkg::CFG_DATA_W'($urandom_range(STORE_CELLS + 1,
                                                         (1 << bfac_pkg::SIZE_W) - 1));
      default: sz = bfac_pkg::CFG_DATA_W'($urandom);
    endcase
    raw = bfac_pkg::CFG_DATA_W'($urandom);
    raw[bfac_pkg::COUNT_W-1:0] = ($urandom_range(0, 9) < 7)
                                 ? bfac_pkg::COUNT_W'($urandom_range(1, 6))
                                 : bfac_pkg::COUNT_W'($urandom_range(0, 31));
    wait_drained();
    if ($urandom_range(0, 1)) begin
      write_reg(bfac_pkg::REG_FILTER_SIZE, sz);
      write_reg(bfac_pkg::REG_HASH_COUNT, raw);
    end else begin
      write_reg(bfac_pkg::REG_HASH_COUNT, raw);
      write_reg(bfac_pkg::REG_FILTER_SIZE, sz);
    end
    calm_in  = ($urandom_range(0, 3) == 0);
    calm_out = ($urandom_range(0, 3) == 0);
  endtask

  // A random batch: mostly adds of fresh keys and checks of keys already added,
  // with some near misses (one flipped key bit) and fully random checks. A flip of
  // bit 0 of the high half leaves h2 unchanged, so that near miss probes the same cells.
  task automatic random_batch(input int unsigned n);
    int unsigned k;
    int unsigned pick;
    bloom_key_t  key;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 || added_keys.size() == 0) begin
        queue_word(bfac_pkg::OP_ADD, rand_key_half(), rand_key_half());
      end else if (pick < 90) begin
        key = added_keys[$urandom_range(0, added_keys.size() - 1)];
        if (pick >= 80) begin
          if ($urandom_range(0, 1)) begin
            key.lo = key.lo ^ (64'd1 << $urandom_range(0, bfac_pkg::KEY_W - 1));
          end else begin
            key.hi = key.hi ^ (64'd1 << $urandom_range(0, bfac_pkg::KEY_W - 1));
          end
        end
        queue_word(bfac_pkg::OP_CHECK, key.lo, key.hi);
      end else begin
        queue_word(bfac_pkg::OP_CHECK, rand_key_half(), rand_key_half());
      end
    end
  endtask

  // Input driver. A word is presented from the queue, held until the block takes it,
  // and then the drawn number of idle cycles passes before the next one. The model
  // scores each word at the edge that accepts it, so answers line up in order.
  always @(posedge clk) begin : drive_words
    bloom_word_t nxt;
    bloom_word_t seen;
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.op       <= bfac_pkg::OP_ADD;
      in_ch.key_low  <= '0;
      in_ch.key_high <= '0;
      in_gap         <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        seen.op       = in_ch.op;
        seen.key_low  = in_ch.key_low;
        seen.key_high = in_ch.key_high;
        answers_due.push_back(filter_answer(seen));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap != 0) begin
          in_gap      <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          nxt = words_to_send.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.op       <= nxt.op;
          in_ch.key_low  <= nxt.key_low;
          in_ch.key_high <= nxt.key_high;
          in_gap         <= draw_gap(calm_in);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every taken result is compared with the oldest answer due;
  // after each one the ready line drops for a drawn number of cycles.
  always @(posedge clk) begin : score_results
    logic        want;
    int unsigned d;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: expected none, actual maybe_present=%b",
                   $time, out_ch.maybe_present);
        end else begin
          want = answers_due.pop_front();
          answers_seen++;
          if (out_ch.maybe_present !== want) begin
            mismatches++;
            $display("%0t: maybe_present mismatch: expected %b, actual %b",
                     $time, want, out_ch.maybe_present);
          end
        end
        d = draw_gap(calm_out);
        out_stall    <= d;
        out_ch.ready <= (d == 0);
      end else if (out_stall != 0) begin
        out_stall    <= out_stall - 1;
        out_ch.ready <= (out_stall == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("bloom_filter_add_check_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_test
    int unsigned c;
    int unsigned b;
    for (c = 0; c < STORE_CELLS; c++) cell_set[c] = 1'b0;
    cur_size  = bfac_pkg::SIZE_RESET;
    cur_count = bfac_pkg::COUNT_RESET;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= bfac_pkg::REG_FILTER_SIZE;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings (full store, four probes). An all-zero key sets cells 0..3; the
    // same key with bit 0 of the high half set gives the same h2 and must hit, while
    // a shifted low half reaches cell 4 and must miss. All-ones keys probe the top of
    // the 64-bit wrap.
    queue_word(bfac_pkg::OP_ADD,   64'd0, 64'd0);
    queue_word(bfac_pkg::OP_CHECK, 64'd0, 64'd0);
    queue_word(bfac_pkg::OP_CHECK, 64'd0, 64'd1);
    queue_word(bfac_pkg::OP_CHECK, 64'd1, 64'd0);
    queue_word(bfac_pkg::OP_ADD,   '1, '1);
    queue_word(bfac_pkg::OP_CHECK, '1, '1);
    queue_word(bfac_pkg::OP_CHECK, '1, {{(bfac_pkg::KEY_W-1){1'b1}}, 1'b0});
    queue_word(bfac_pkg::OP_CHECK, 64'h8000_0000_0000_0000, 64'h5555_aaaa_5555_aaaa);

    // Writes past the register map must leave both registers alone; then a zero
    // size, where an add does nothing and a check always answers 0.
    wait_drained();
    write_reg(REG_UNMAPPED_LO, '1);
    write_reg(REG_UNMAPPED_HI, '0);
    write_reg(bfac_pkg::REG_FILTER_SIZE, '0);
    queue_word(bfac_pkg::OP_ADD,   64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    queue_word(bfac_pkg::OP_CHECK, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);

    // One cell and no probes: a check answers 1 with nothing probed, an add is a no-op.
    wait_drained();
    write_reg(bfac_pkg::REG_FILTER_SIZE, 17'd1);
    write_reg(bfac_pkg::REG_HASH_COUNT, '0);
    queue_word(bfac_pkg::OP_CHECK, rand_key_half(), rand_key_half());
    queue_word(bfac_pkg::OP_ADD,   rand_key_half(), rand_key_half());

    // Both registers above their limits, which the block saturates to the full
    // store and sixteen probes.
    wait_drained();
    write_reg(bfac_pkg::REG_FILTER_SIZE, '1);
    write_reg(bfac_pkg::REG_HASH_COUNT,
              {{(bfac_pkg::CFG_DATA_W-bfac_pkg::COUNT_W){1'b0}}, {bfac_pkg::COUNT_W{1'b1}}});
    queue_word(bfac_pkg::OP_ADD,   64'hdead_beef_0000_0001, 64'h0000_0001_dead_beef);
    queue_word(bfac_pkg::OP_CHECK, 64'hdead_beef_0000_0001, 64'h0000_0001_dead_beef);
    queue_word(bfac_pkg::OP_CHECK, rand_key_half(), rand_key_half());

    // One cell and the maximum probe count: once any add lands, every check hits.
    wait_drained();
    write_reg(bfac_pkg::REG_FILTER_SIZE, 17'd1);
    write_reg(bfac_pkg::REG_HASH_COUNT,
              {{(bfac_pkg::CFG_DATA_W-bfac_pkg::COUNT_W){1'b0}}, 5'(bfac_pkg::MAX_HASHES)});
    queue_word(bfac_pkg::OP_ADD,   rand_key_half(), rand_key_half());
    queue_word(bfac_pkg::OP_CHECK, rand_key_half(), rand_key_half());

    // Random part: ten settings with sixty words each.
    for (b = 0; b < 10; b++) begin
      pick_setting();
      random_batch(60);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("bloom_filter_add_check_unit verification clean");
    end else begin
      $display("bloom_filter_add_check_unit verification failed");
    end
    $finish;
  end

endmodule
